/* sv/mbe_pkg.sv */
// ----------------------------------------------------------------------------
// mbe_pkg
// Types, register indexes, reset values and saturation helpers shared by the
// Mandelbrot escape-time evaluator.
// ----------------------------------------------------------------------------
package mbe_pkg;

    localparam int COLUMN_W = 9;
    localparam int ROW_W    = 8;
    localparam int COORD_W  = 32;
    localparam int STEP_W   = 28;
    localparam int COUNT_W  = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 32;

    localparam logic signed [COORD_W-1:0] X_ORIGIN_RST = -32'sd671088640;
    localparam logic        [STEP_W-1:0]  X_STEP_RST   = 28'd2684355;
    localparam logic signed [COORD_W-1:0] Y_ORIGIN_RST = -32'sd268435456;
    localparam logic        [STEP_W-1:0]  Y_STEP_RST   = 28'd2684355;
    localparam logic        [COUNT_W-1:0] LIMIT_RST    = 16'd1000;

    localparam logic signed [63:0] SAT_MAX = 64'sd2147483647;
    localparam logic signed [63:0] SAT_MIN = -64'sd2147483648;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_X_ORIGIN        = 3'd0,
        REG_X_STEP          = 3'd1,
        REG_Y_ORIGIN        = 3'd2,
        REG_Y_STEP          = 3'd3,
        REG_ITERATION_LIMIT = 3'd4
    } mbe_reg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CRE,
        ST_CIM,
        ST_CFIN,
        ST_LOOP,
        ST_SQR,
        ST_SQI,
        ST_SQM,
        ST_DONE
    } mbe_state_t;

    typedef struct packed {
        logic [COLUMN_W-1:0] column;
        logic [ROW_W-1:0]    row;
    } mbe_in_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] point_real;
        logic signed [COORD_W-1:0] point_imag;
        logic [COUNT_W-1:0]        iteration_count;
        logic                      escaped;
    } mbe_out_t;

    function automatic logic signed [63:0] sext64(input logic signed [COORD_W-1:0] v);
        return {{(64-COORD_W){v[COORD_W-1]}}, v};
    endfunction

    function automatic logic signed [COORD_W-1:0] sat32(input logic signed [63:0] v);
        if (v > SAT_MAX) begin
            return SAT_MAX[COORD_W-1:0];
        end else if (v < SAT_MIN) begin
            return SAT_MIN[COORD_W-1:0];
        end else begin
            return v[COORD_W-1:0];
        end
    endfunction

endpackage

/* sv/mandelbrot_escape_time.sv */
// ----------------------------------------------------------------------------
// mandelbrot_escape_time
// Escape-time evaluator for one grid point of the Mandelbrot set.
//
// An input transfer on s_ carries a column and row index. The block forms
// c = (x_origin + column*x_step) + i(y_origin + row*y_step) in signed fixed
// point, iterates z = z*z + c from z = 0 while |z|^2 < 4 and the count is
// below iteration_limit, and returns c, the count and an escaped flag as one
// result transfer on m_. Indexes beyond the grid are clamped to its edge.
// The cfg_ channel writes the five registers; it is always ready, and it is
// to be used only while no point is in flight: the user must keep to this,
// as the block itself does not enforce it. One signed 32 by 32 multiplier
// with a registered product does all the work: the CRE, CIM and CFIN states
// form c, each iteration passes through the cross term, the two squares and
// the magnitude check, and a final check and the output load follow. The
// block is ready for the next point as soon as its result is shown.
// The block takes a new point while a result still waits on m_; if that
// result is still stalled when the next one is ready, the block holds it
// until m_ready frees the output register.
// Reset restores the register defaults and empties the block.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time #(
    parameter int COLUMN_COUNT  = 512,
    parameter int ROW_COUNT     = 256,
    parameter int FRACTION_BITS = 28
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  mbe_pkg::mbe_in_t              s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output mbe_pkg::mbe_out_t             m_data,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [mbe_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mbe_pkg::CFG_DAT_W-1:0] cfg_data
);
    import mbe_pkg::*;

    localparam logic [COLUMN_W-1:0] COL_LIM = (COLUMN_COUNT - 1 > (2**COLUMN_W) - 1) ?
        {COLUMN_W{1'b1}} : COLUMN_W'(COLUMN_COUNT - 1);
    localparam logic [ROW_W-1:0] ROW_LIM = (ROW_COUNT - 1 > (2**ROW_W) - 1) ?
        {ROW_W{1'b1}} : ROW_W'(ROW_COUNT - 1);
    localparam logic signed [63:0] FOUR = 64'sd4 <<< FRACTION_BITS;

    mbe_state_t state_reg, state_next;

    logic signed [COORD_W-1:0] x_origin_reg, y_origin_reg;
    logic [STEP_W-1:0]         x_step_reg, y_step_reg;
    logic [COUNT_W-1:0]        limit_reg;

    logic [COLUMN_W-1:0]       col_reg;
    logic [ROW_W-1:0]          row_reg;
    logic signed [COORD_W-1:0] cr_reg, ci_reg, zr_reg, zi_reg, sq_r_reg, sq_i_reg;
    logic [COUNT_W-1:0]        count_reg;
    logic signed [63:0]        prod_reg;
    logic                      m_valid_reg;
    mbe_out_t                  m_data_reg;

    logic signed [COORD_W-1:0] mul_a, mul_b;
    logic signed [COORD_W-1:0] zr_new, zi_new, sq_new, mag, coord_new;
    logic                      keep_going, out_free;

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign out_free  = !m_valid_reg || m_ready;

    assign zr_new = sat32(sext64(sat32(sext64(sq_r_reg) - sext64(sq_i_reg)))
                          + sext64(cr_reg));
    assign zi_new = sat32(sext64(sat32(prod_reg >>> (FRACTION_BITS - 1))) + sext64(ci_reg));
    assign sq_new = sat32(prod_reg >>> FRACTION_BITS);
    assign mag    = sat32(sext64(sq_r_reg) + sext64(sq_i_reg));
    assign keep_going = (sext64(mag) < FOUR) && (count_reg < limit_reg);

    always_comb begin
        unique case (state_reg)
            ST_CIM:  coord_new = sat32(sext64(x_origin_reg) + prod_reg);
            default: coord_new = sat32(sext64(y_origin_reg) + prod_reg);
        endcase
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_CRE;
                end
            end
            ST_CRE:  state_next = ST_CIM;
            ST_CIM:  state_next = ST_CFIN;
            ST_CFIN: state_next = ST_LOOP;
            ST_LOOP: state_next = keep_going ? ST_SQR : ST_DONE;
            ST_SQR:  state_next = ST_SQI;
            ST_SQI:  state_next = ST_SQM;
            ST_SQM:  state_next = ST_LOOP;
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        mul_a = zr_reg;
        mul_b = zi_reg;
        unique case (state_reg)
            ST_CRE: begin
                mul_a = {{(COORD_W-COLUMN_W){1'b0}}, col_reg};
                mul_b = {{(COORD_W-STEP_W){1'b0}}, x_step_reg};
            end
            ST_CIM: begin
                mul_a = {{(COORD_W-ROW_W){1'b0}}, row_reg};
                mul_b = {{(COORD_W-STEP_W){1'b0}}, y_step_reg};
            end
            ST_SQR: begin
                mul_a = zr_reg;
                mul_b = zr_reg;
            end
            ST_SQI: begin
                mul_a = zi_reg;
                mul_b = zi_reg;
            end
            default: begin
                mul_a = zr_reg;
                mul_b = zi_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_valid_reg  <= 1'b0;
            x_origin_reg <= X_ORIGIN_RST;
            x_step_reg   <= X_STEP_RST;
            y_origin_reg <= Y_ORIGIN_RST;
            y_step_reg   <= Y_STEP_RST;
            limit_reg    <= LIMIT_RST;
        end else begin
            state_reg <= state_next;
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (state_reg == ST_DONE && out_free) begin
                m_valid_reg <= 1'b1;
            end
            if (cfg_valid) begin
                unique case (cfg_index)
                    REG_X_ORIGIN:        x_origin_reg <= cfg_data;
                    REG_X_STEP:          x_step_reg   <= cfg_data[STEP_W-1:0];
                    REG_Y_ORIGIN:        y_origin_reg <= cfg_data;
                    REG_Y_STEP:          y_step_reg   <= cfg_data[STEP_W-1:0];
                    REG_ITERATION_LIMIT: limit_reg    <= cfg_data[COUNT_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
        case (state_reg)
            ST_IDLE: begin
                col_reg <= (s_data.column > COL_LIM) ? COL_LIM : s_data.column;
                row_reg <= (s_data.row > ROW_LIM) ? ROW_LIM : s_data.row;
            end
            ST_CIM: cr_reg <= coord_new;
            ST_CFIN: begin
                ci_reg    <= coord_new;
                zr_reg    <= '0;
                zi_reg    <= '0;
                sq_r_reg  <= '0;
                sq_i_reg  <= '0;
                count_reg <= '0;
            end
            ST_LOOP: zr_reg <= zr_new;
            ST_SQR:  zi_reg <= zi_new;
            ST_SQI:  sq_r_reg <= sq_new;
            ST_SQM: begin
                sq_i_reg  <= sq_new;
                count_reg <= count_reg + 1'b1;
            end
            ST_DONE: begin
                if (out_free) begin
                    m_data_reg.point_real      <= cr_reg;
                    m_data_reg.point_imag      <= ci_reg;
                    m_data_reg.iteration_count <= count_reg;
                    m_data_reg.escaped         <= (sext64(mag) >= FOUR);
                end
            end
            default: ;
        endcase
    end

`ifndef SYNTHESIS
    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_CRE))
        else $error("input transfer did not start the coordinate sequence");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_LOOP || state_reg == ST_SQR || state_reg == ST_SQI
         || state_reg == ST_SQM) |-> (count_reg <= limit_reg))
        else $error("iteration count passed the limit");

    a_inside_at_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_data_reg.escaped) |-> (m_data_reg.iteration_count == limit_reg))
        else $error("point reported inside before the limit was reached");

    a_escape_needs_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.escaped) |-> (m_data_reg.iteration_count != '0))
        else $error("point reported escaped without any iteration");
`endif

endmodule
